[hdl/climb_detector_hysteresis_unit_assert.svh]
// Assertion macros used by the checker file of the climb detector.
`ifndef CLIMB_DETECTOR_HYSTERESIS_UNIT_ASSERT_SVH
`define CLIMB_DETECTOR_HYSTERESIS_UNIT_ASSERT_SVH

// Property that must hold at every edge outside reset.
`define CDH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define CDH_ASSERT_NEXT(label, cond, follow, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (follow)) else $error(msg);

`endif

[hdl/cdh_pkg.sv]
// Types, constants and per-point update functions of the climb detector.
package cdh_pkg;

  localparam int AltW     = 18;
  localparam int TimeW    = 32;
  localparam int MetreW   = 16;
  localparam int AscW     = 14;
  localparam int CntW     = 16;
  localparam int HystW    = 10;
  localparam int MinAscW  = 16;
  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] CfgHysteresis = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMinAscent  = 1'b1;

  localparam logic [HystW-1:0]   HystDefault   = 10'd30;
  localparam logic [HystW-1:0]   HystMinValid  = 10'd1;
  localparam logic [MinAscW-1:0] MinAscDefault = 16'd1000;

  localparam logic [AscW-1:0] AscMax = '1;
  localparam logic [CntW-1:0] CntMax = '1;

  // floor(x / 10) = (x * Div10Mul) >> Div10Shift for x below 2^18
  localparam logic [AltW-1:0] Div10Mul   = 18'd209716;
  localparam int              Div10Shift = 21;

  typedef struct packed {
    logic signed [AltW-1:0] altitude_dm;
    logic [TimeW-1:0]       time_ms;
    logic                   ride_start;
  } sample_t;

  typedef struct packed {
    logic [TimeW-1:0] climb_start_ms;
    logic [TimeW-1:0] climb_stop_ms;
    logic [AscW-1:0]  ascent_m;
    logic [CntW-1:0]  climb_number;
    logic             last_of_run;
  } climb_t;

  typedef struct packed {
    logic signed [MetreW-1:0] prev_alt;
    logic [TimeW-1:0]         prev_time;
    logic signed [MetreW-1:0] older_alt;
    logic [1:0]               rec_count;
    logic signed [MetreW-1:0] ext_alt;
    logic [TimeW-1:0]         ext_time;
    logic                     ext_valid;
    logic [CntW-1:0]          climb_count;
  } track_t;

  typedef struct packed {
    track_t st;
    logic   emit;
    climb_t word;
  } rec_t;

  typedef struct packed {
    logic [1:0] n;
    climb_t     w0;
    climb_t     w1;
  } push_t;

  // Truncating divide by ten of a decimetre altitude.
  function automatic logic signed [MetreW-1:0] div10(logic signed [AltW-1:0] x);
    logic [AltW-1:0]     mag;
    logic [2*AltW-1:0]   prod;
    logic [MetreW-2:0]   q;
    mag  = x[AltW-1] ? AltW'(~x + 1'b1) : AltW'(x);
    prod = mag * Div10Mul;
    q    = prod[Div10Shift +: (MetreW-1)];
    return x[AltW-1] ? $signed(MetreW'(~{1'b0, q} + 1'b1)) : $signed({1'b0, q});
  endfunction

  // Records one point and checks whether the previous point closes a climb.
  function automatic rec_t record_point(track_t st, logic signed [MetreW-1:0] alt_m,
                                        logic [TimeW-1:0] t, logic [MinAscW-1:0] min_asc);
    rec_t               r;
    logic               peak;
    logic               trough;
    logic signed [16:0] asc;
    logic signed [21:0] asc10;
    r      = '0;
    r.st   = st;
    peak   = (st.prev_alt > st.older_alt) && (st.prev_alt > alt_m);
    trough = (st.prev_alt < st.older_alt) && (st.prev_alt < alt_m);
    asc    = $signed({st.prev_alt[MetreW-1], st.prev_alt})
           - $signed({st.ext_alt[MetreW-1], st.ext_alt});
    asc10  = $signed({{2{asc[16]}}, asc, 3'b000}) + $signed({{4{asc[16]}}, asc, 1'b0});
    if (st.rec_count == 2'd2 && (peak || trough)) begin
      if (st.ext_valid && asc10 >= $signed({6'b0, min_asc})) begin
        if (r.st.climb_count != CntMax) begin
          r.st.climb_count = r.st.climb_count + 1'b1;
        end
        r.emit                = 1'b1;
        r.word.climb_start_ms = st.ext_time;
        r.word.climb_stop_ms  = st.prev_time;
        if (asc > $signed({3'b000, AscMax})) begin
          r.word.ascent_m = AscMax;
        end else if (asc < 0) begin
          r.word.ascent_m = '0;
        end else begin
          r.word.ascent_m = asc[AscW-1:0];
        end
        r.word.climb_number = r.st.climb_count;
      end
      r.st.ext_alt   = st.prev_alt;
      r.st.ext_time  = st.prev_time;
      r.st.ext_valid = 1'b1;
    end
    r.st.older_alt = st.prev_alt;
    r.st.prev_alt  = alt_m;
    r.st.prev_time = t;
    if (st.rec_count != 2'd2) begin
      r.st.rec_count = st.rec_count + 1'b1;
    end
    return r;
  endfunction

endpackage

[hdl/cdh_stream_if.sv]
// Valid/ready stream channel carrying one payload word.
interface cdh_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hdl/cdh_out_queue.sv]
// Two-word result queue: takes up to two words per cycle, hands out one.
module cdh_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  cdh_pkg::push_t     push,
  output logic [1:0]         free,
  cdh_stream_if.source       climbs
);
  import cdh_pkg::*;

  climb_t     slot0;
  climb_t     slot1;
  logic [1:0] count;

  climb_t     slot0_next;
  climb_t     slot1_next;
  logic [1:0] count_next;
  logic [1:0] count_pop;
  logic       pop;

  assign climbs.valid   = (count != 2'd0);
  assign climbs.payload = slot0;
  assign pop            = climbs.valid && climbs.ready;
  assign free           = 2'd2 - count;

  always_comb begin
    slot0_next = slot0;
    slot1_next = slot1;
    count_pop  = count;
    if (pop) begin
      slot0_next = slot1;
      count_pop  = count - 1'b1;
    end
    if (push.n != 2'd0) begin
      if (count_pop == 2'd0) begin
        slot0_next = push.w0;
      end else begin
        slot1_next = push.w0;
      end
    end
    if (push.n == 2'd2) begin
      slot1_next = push.w1;
    end
    count_next = count_pop + push.n;
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

endmodule

[hdl/climb_detector_hysteresis_unit.sv]
// Climb detector: hysteresis tracking of altitude samples, extremum pairing, climb output.
// Accepts one sample per clock unless the output queue holds it back. A sample is
// registered, then its tracking update and up to two climb words are computed
// combinationally and written into a two-word output queue, so a climb word passes
// the input register and then the queue register before it is presented on the output.
// The queue is the only limit on rate: a sample that yields words waits in the input
// register until the queue has room for all of them. Room is counted before the
// output's own hand-out in the same cycle. Output stalls hold the input side once
// the queue and input register fill.
module climb_detector_hysteresis_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [cdh_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [cdh_pkg::CfgDataW-1:0]  cfg_data,
  cdh_stream_if.sink                    samples,
  cdh_stream_if.source                  climbs
);
  import cdh_pkg::*;

  logic [HystW-1:0]   hysteresis_dm;
  logic [MinAscW-1:0] min_ascent_dm;

  logic                     s1_valid;
  sample_t                  s1_word;
  logic signed [MetreW-1:0] s1_alt_m;

  logic signed [MetreW-1:0] tracked_alt_m;
  track_t                   track;

  logic                     advance;
  logic [1:0]               free;
  logic [1:0]               n_words;
  push_t                    push;

  logic [HystW-1:0]         h_eff;
  logic signed [19:0]       h20;
  logic signed [19:0]       alt20;
  logic signed [MetreW-1:0] tracked0;
  logic signed [MetreW-1:0] tracked1;
  logic signed [MetreW-1:0] tracked_next;
  logic signed [19:0]       t10_0;
  logic signed [19:0]       t10_1;
  logic                     up;
  logic                     down;
  track_t                   st0;
  track_t                   st1;
  track_t                   track_next;
  rec_t                     rec0;
  rec_t                     rec1;
  logic                     e0;
  logic                     e1;

  always_comb begin
    h_eff    = (hysteresis_dm <= HystMinValid) ? HystDefault : hysteresis_dm;
    h20      = $signed({10'b0, h_eff});
    alt20    = $signed({{2{s1_word.altitude_dm[AltW-1]}}, s1_word.altitude_dm});
    tracked0 = s1_word.ride_start ? s1_alt_m : tracked_alt_m;
    st0      = s1_word.ride_start ? '0 : track;
    t10_0    = $signed({tracked0[MetreW-1], tracked0, 3'b000})
             + $signed({{3{tracked0[MetreW-1]}}, tracked0, 1'b0});
    up       = alt20 > (t10_0 + h20);
    rec0     = record_point(st0, s1_alt_m, s1_word.time_ms, min_ascent_dm);
    st1      = up ? rec0.st : st0;
    tracked1 = up ? s1_alt_m : tracked0;
    t10_1    = $signed({tracked1[MetreW-1], tracked1, 3'b000})
             + $signed({{3{tracked1[MetreW-1]}}, tracked1, 1'b0});
    down     = alt20 < (t10_1 - h20);
    rec1     = record_point(st1, s1_alt_m, s1_word.time_ms, min_ascent_dm);
    track_next   = down ? rec1.st : st1;
    tracked_next = down ? s1_alt_m : tracked1;
    e0       = up && rec0.emit;
    e1       = down && rec1.emit;
    n_words  = {1'b0, e0} + {1'b0, e1};
  end

  assign advance       = s1_valid && (n_words <= free);
  assign samples.ready = !s1_valid || advance;

  always_comb begin
    push.n              = advance ? n_words : 2'd0;
    push.w0             = e0 ? rec0.word : rec1.word;
    push.w0.last_of_run = !(e0 && e1);
    push.w1             = rec1.word;
    push.w1.last_of_run = 1'b1;
  end

  cdh_out_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .free   (free),
    .climbs (climbs)
  );

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_word  <= samples.payload;
      s1_alt_m <= div10(samples.payload.altitude_dm);
    end
    if (rst) begin
      s1_valid      <= 1'b0;
      tracked_alt_m <= '0;
      track         <= '0;
      hysteresis_dm <= HystDefault;
      min_ascent_dm <= MinAscDefault;
    end else begin
      if (samples.valid && samples.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        tracked_alt_m <= tracked_next;
        track         <= track_next;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CfgHysteresis: hysteresis_dm <= cfg_data[HystW-1:0];
          CfgMinAscent:  min_ascent_dm <= cfg_data[MinAscW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

[hdl/cdh_checker.sv]
// Port-level checks of the climb detector and their binding to the top level.
`include "climb_detector_hysteresis_unit_assert.svh"

module cdh_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input cdh_pkg::climb_t  out_word
);
  import cdh_pkg::*;

  // an empty queue means the input register can always drain
  `CDH_ASSERT_ALWAYS(a_idle_takes_input, !out_valid |-> in_ready, "input stalled with idle output")
  `CDH_ASSERT_ALWAYS(a_number_nonzero, out_valid |-> (out_word.climb_number != '0), "climb number zero")
  `CDH_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid, "output word dropped")
  `CDH_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_word), "stalled word changed")

endmodule

bind climb_detector_hysteresis_unit cdh_checker u_cdh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (climbs.valid),
  .out_ready (climbs.ready),
  .out_word  (climbs.payload)
);

[tb/tb_top.sv]
// Self-checking climb detector testbench: directed, saturation, random and stall tests.
`timescale 1ns / 100ps

module tb_top;
  import cdh_pkg::*;

  localparam int AltHi = 131071;
  localparam int AltLo = -131072;
  localparam int PrintCap = 40;

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  cdh_stream_if #(.payload_t(sample_t)) samples_if ();
  cdh_stream_if #(.payload_t(climb_t))  climbs_if ();

  climb_detector_hysteresis_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples_if),
    .climbs    (climbs_if)
  );

  // predictor copy of registers and ride state
  logic [HystW-1:0]   hyst_reg;
  logic [MinAscW-1:0] min_asc_reg;
  int                 tracked_m;
  int                 last_pt_m;
  int                 prior_pt_m;
  int                 ext_m;
  logic [TimeW-1:0]   last_pt_ms;
  logic [TimeW-1:0]   ext_ms;
  int                 pts_seen;
  bit                 ext_ok;
  logic [CntW-1:0]    n_climbs;
  climb_t             step_climbs [2];
  int                 step_n;

  climb_t climbs_due [$];

  int sender_idle_pct = 0;
  int stall_pct = 0;
  bit climbs_held = 1'b0;
  int samples_sent = 0;
  int rides_started = 0;
  int words_checked = 0;
  int mismatches = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic report_mismatch(string what);
    if (mismatches < PrintCap) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("word %0d %s got %0d want %0d", words_checked, field, got, want));
    end
  endtask

  function automatic void clear_ride_state();
    tracked_m  = 0;
    last_pt_m  = 0;
    prior_pt_m = 0;
    ext_m      = 0;
    last_pt_ms = '0;
    ext_ms     = '0;
    pts_seen   = 0;
    ext_ok     = 1'b0;
    n_climbs   = '0;
  endfunction

  // Records one point; the previous point may turn out to be a peak or trough.
  function automatic void add_point(int alt_m, logic [TimeW-1:0] t_ms);
    int     rise;
    climb_t c;
    c = '0;
    rise = last_pt_m - ext_m;
    if (pts_seen == 2 && ((last_pt_m > prior_pt_m && last_pt_m > alt_m) ||
                          (last_pt_m < prior_pt_m && last_pt_m < alt_m))) begin
      if (ext_ok && rise * 10 >= int'(min_asc_reg) && step_n < 2) begin
        if (n_climbs != CntMax) begin
          n_climbs++;
        end
        c.climb_start_ms = ext_ms;
        c.climb_stop_ms  = last_pt_ms;
        c.ascent_m       = (rise > int'(AscMax)) ? AscMax : (rise < 0) ? '0 : AscW'(rise);
        c.climb_number   = n_climbs;
        step_climbs[step_n] = c;
        step_n++;
      end
      ext_m  = last_pt_m;
      ext_ms = last_pt_ms;
      ext_ok = 1'b1;
    end
    prior_pt_m = last_pt_m;
    last_pt_m  = alt_m;
    last_pt_ms = t_ms;
    if (pts_seen < 2) begin
      pts_seen++;
    end
  endfunction

  function automatic void track_sample(sample_t s);
    int alt;
    int h;
    alt = $signed(s.altitude_dm);
    h = (hyst_reg <= HystMinValid) ? int'(HystDefault) : int'(hyst_reg);
    step_n = 0;
    if (s.ride_start) begin
      clear_ride_state();
      tracked_m = alt / 10;
    end
    if (alt > tracked_m * 10 + h) begin
      tracked_m = alt / 10;
      add_point(tracked_m, s.time_ms);
    end
    // down check sees the updated tracked altitude
    if (alt < tracked_m * 10 - h) begin
      tracked_m = alt / 10;
      add_point(tracked_m, s.time_ms);
    end
    if (step_n > 0) begin
      step_climbs[step_n - 1].last_of_run = 1'b1;
    end
    for (int i = 0; i < step_n; i++) begin
      climbs_due.push_back(step_climbs[i]);
    end
  endfunction

  task automatic send_sample(int alt_dm, logic [TimeW-1:0] t_ms, bit start);
    sample_t s;
    s.altitude_dm = AltW'(alt_dm);
    s.time_ms     = t_ms;
    s.ride_start  = start;
    while ($urandom_range(99) < sender_idle_pct) begin
      samples_if.valid <= 1'b0;
      @(posedge clk);
    end
    samples_if.valid   <= 1'b1;
    samples_if.payload <= s;
    @(posedge clk);
    while (!samples_if.ready) begin
      @(posedge clk);
    end
    track_sample(s);
    samples_sent++;
    if (start) begin
      rides_started++;
    end
  endtask

  task automatic set_thresholds(logic [HystW-1:0] hyst, logic [MinAscW-1:0] min_asc);
    cfg_wr_en <= 1'b1;
    cfg_index <= CfgHysteresis;
    cfg_data  <= CfgDataW'(hyst);
    @(posedge clk);
    cfg_index <= CfgMinAscent;
    cfg_data  <= min_asc;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    hyst_reg    = hyst;
    min_asc_reg = min_asc;
  endtask

  task automatic wait_idle();
    int waited;
    waited = 0;
    samples_if.valid <= 1'b0;
    while (climbs_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
  endtask

  // One ride of alternating deep troughs and high peaks: every peak after the first closes a climb.
  task automatic send_swings(int count);
    logic [TimeW-1:0] t;
    int               alt;
    t = '0;
    send_sample(0, t, 1'b1);
    for (int i = 0; i < count; i++) begin
      t = t + 32'd1000;
      alt = i[0] ? -int'($urandom_range(5000)) : int'($urandom_range(90000, 1100));
      send_sample(alt, t, 1'b0);
    end
  endtask

  // Random walk with trend reversals, plus occasional wild samples and restarts.
  task automatic send_ride(int step_max);
    int               alt;
    int               len;
    int               dir;
    int               seg;
    logic [TimeW-1:0] t;
    len = ($urandom_range(99) < 85) ? $urandom_range(40, 3) : $urandom_range(2);
    alt = int'($urandom_range(30000)) - 5000;
    t = ($urandom_range(99) < 10) ? $urandom : $urandom_range(50000);
    dir = $urandom_range(1) ? 1 : -1;
    seg = $urandom_range(10, 1);
    send_sample(alt, t, 1'b1);
    for (int i = 0; i < len; i++) begin
      seg--;
      if (seg == 0) begin
        dir = -dir;
        seg = $urandom_range(10, 1);
      end
      alt = alt + dir * int'($urandom_range(step_max));
      if ($urandom_range(99) < 6) begin
        alt = int'($signed(AltW'($urandom)));
      end
      alt = (alt > AltHi) ? AltHi : (alt < AltLo) ? AltLo : alt;
      t = t + $urandom_range(4000, 1);
      send_sample(alt, t, $urandom_range(99) < 3);
    end
  endtask

  task automatic test_directed();
    sender_idle_pct = 0;
    stall_pct = 0;
    // no ride start yet: tracked altitude starts at zero
    send_sample(500, 0, 1'b0);
    send_sample(-100, 10, 1'b0);
    send_sample(2000, 20, 1'b0);
    send_sample(100, 30, 1'b0);
    send_sample(125, 40, 1'b0);
    // full-scale swings, ascent saturates
    send_sample(AltLo, 32'hFFFF_FFFF, 1'b1);
    send_sample(AltHi, 32'h0000_0000, 1'b0);
    send_sample(AltLo, 32'hFFFF_FFFF, 1'b0);
    send_sample(AltHi, 32'h5555_5555, 1'b0);
    send_sample(AltLo, 32'hAAAA_AAAA, 1'b0);
    send_sample(0, 7, 1'b0);
    // short rides and truncation of negative altitudes
    send_sample(300, 100, 1'b1);
    send_sample(900, 200, 1'b0);
    send_sample(-1234, 0, 1'b1);
    send_sample(-1279, 50, 1'b0);
    wait_idle();
  endtask

  task automatic test_small_hysteresis();
    // one sample recording two points on the negative side
    set_thresholds(10'd5, 16'd100);
    send_sample(-500, 0, 1'b1);
    send_sample(-489, 10, 1'b0);
    send_sample(-300, 20, 1'b0);
    send_sample(-1700, 30, 1'b0);
    wait_idle();
    set_thresholds(10'd0, 16'd0);
    send_sample(1000, 0, 1'b1);
    send_sample(1025, 10, 1'b0);
    wait_idle();
    set_thresholds(10'd1, 16'hFFFF);
    send_sample(1000, 0, 1'b1);
    send_sample(1031, 10, 1'b0);
    wait_idle();
    set_thresholds(10'd2, 16'd50000);
    send_sample(19, 0, 1'b1);
    send_sample(1013, 10, 1'b0);
    wait_idle();
    set_thresholds(10'h3FF, 16'd0);
    send_sample(0, 0, 1'b1);
    send_sample(1024, 10, 1'b0);
    send_sample(-2100, 20, 1'b0);
    send_sample(3000, 30, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int                 idle_mix [4] = '{0, 46, 0, 12};
    int                 stall_mix [4] = '{0, 0, 46, 12};
    int                 start;
    int                 step_max;
    logic [HystW-1:0]   hyst;
    logic [MinAscW-1:0] min_asc;
    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(5))
        0: hyst = 10'd0;
        1: hyst = 10'd1;
        2: hyst = 10'h3FF;
        3: hyst = HystW'($urandom_range(8, 2));
        default: hyst = HystW'($urandom_range(1000, 9));
      endcase
      case ($urandom_range(5))
        0: min_asc = 16'd100;
        1: min_asc = 16'd50000;
        2: min_asc = 16'hFFFF;
        3: min_asc = 16'd0;
        default: min_asc = MinAscW'($urandom_range(3000, 100));
      endcase
      set_thresholds(hyst, min_asc);
      sender_idle_pct = idle_mix[p % 4];
      stall_pct = stall_mix[p % 4];
      start = samples_sent;
      while (samples_sent - start < 145) begin
        case ($urandom_range(3))
          0: step_max = 60;
          1: step_max = 400;
          2: step_max = 3000;
          default: step_max = 30000;
        endcase
        send_ride(step_max);
      end
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    set_thresholds(HystDefault, MinAscDefault);
    sender_idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        climbs_held <= 1'b1;
        repeat (300) @(posedge clk);
        climbs_held <= 1'b0;
      end
      send_swings(80);
    join
    wait_idle();
  endtask

  always @(posedge clk) begin
    climb_t want;
    climb_t got;
    climbs_if.ready <= !climbs_held && ($urandom_range(99) >= stall_pct);
    if (!rst && climbs_if.valid && climbs_if.ready) begin
      got = climbs_if.payload;
      if (climbs_due.size() == 0) begin
        report_mismatch($sformatf("climb word with nothing expected, stop %0d",
                                  got.climb_stop_ms));
      end else begin
        want = climbs_due.pop_front();
        check_field("climb_start_ms", got.climb_start_ms, want.climb_start_ms);
        check_field("climb_stop_ms", got.climb_stop_ms, want.climb_stop_ms);
        check_field("ascent_m", 32'(got.ascent_m), 32'(want.ascent_m));
        check_field("climb_number", 32'(got.climb_number), 32'(want.climb_number));
        check_field("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
        words_checked++;
      end
    end
  end

  initial begin
    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_index          <= CfgHysteresis;
    cfg_data           <= '0;
    samples_if.valid   <= 1'b0;
    samples_if.payload <= '0;
    hyst_reg    = HystDefault;
    min_asc_reg = MinAscDefault;
    clear_ride_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_small_hysteresis();
    test_random_traffic();
    test_backpressure();

    if (climbs_due.size() != 0) begin
      report_mismatch($sformatf("%0d climb words never arrived", climbs_due.size()));
    end
    $display("Ran %0d samples over %0d rides with varied thresholds, gaps and stalls;",
             samples_sent, rides_started);
    $display("%0d climb words compared, including a long output hold-off.",
             words_checked);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("Timed out with %0d climb words outstanding", climbs_due.size());
    $display("Verification failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/cdh_pkg.sv
hdl/cdh_stream_if.sv
hdl/cdh_out_queue.sv
hdl/climb_detector_hysteresis_unit.sv
hdl/cdh_checker.sv
tb/tb_top.sv
